// File: rtl/nearest_neighbor_scale_address_assert.svh
// Assertion macros for the nearest-neighbor scaler address pipeline.
`ifndef NEAREST_NEIGHBOR_SCALE_ADDRESS_ASSERT_SVH
`define NEAREST_NEIGHBOR_SCALE_ADDRESS_ASSERT_SVH

// Same-cycle check, clocked on clk, off while rst_n is low.
`define NNSA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Next-cycle check: when pre holds, post must hold in the next cycle.
`define NNSA_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// File: rtl/nnsa_pkg.sv
// Types, constants and helper functions for the nearest-neighbor scaler address pipeline.
`timescale 1ns / 1ps

package nnsa_pkg;

    localparam int MAX_DIM         = 4096;
    localparam int DIM_W           = 13;
    localparam int COORD_W         = 12;
    localparam int ADDR_W          = 24;
    localparam int NUM_REGS        = 6;
    localparam int IDX_W           = 3;
    localparam int PROD_W          = COORD_W + DIM_W;
    localparam int STEPS_PER_STAGE = 3;
    localparam int DIV_STAGES      = COORD_W / STEPS_PER_STAGE;
    localparam int NUM_STAGES      = DIV_STAGES + 2;

    typedef logic [DIM_W-1:0]   dim_t;
    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [ADDR_W-1:0]  addr_t;

    typedef enum logic [IDX_W-1:0] {
        REG_SOURCE_WIDTH     = 3'd0,
        REG_SOURCE_HEIGHT    = 3'd1,
        REG_SOURCE_ROW_PITCH = 3'd2,
        REG_TARGET_WIDTH     = 3'd3,
        REG_TARGET_HEIGHT    = 3'd4,
        REG_TARGET_ROW_PITCH = 3'd5
    } reg_index_t;

    // Long-division lane: partial remainder and the word that shifts the
    // dividend bits out at the top and the quotient bits in at the bottom.
    typedef struct packed {
        dim_t   rem;
        coord_t quo;
    } div_lane_t;

    // Sideband that travels with an item through the divider stages.
    typedef struct packed {
        logic  x_over;
        logic  y_over;
        addr_t target_address;
    } side_t;

    // 0 reads as 1, anything above MAX_DIM saturates.
    function automatic dim_t eff_dim(dim_t v);
        dim_t r;
        r = v;
        if (v == '0)
        begin
            r = DIM_W'(1);
        end
        else if (v > DIM_W'(MAX_DIM))
        begin
            r = DIM_W'(MAX_DIM);
        end
        return r;
    endfunction

    // STEPS_PER_STAGE restoring division steps.
    function automatic div_lane_t div_steps(div_lane_t lane, dim_t d);
        div_lane_t       r;
        logic [DIM_W:0]  t;
        r = lane;
        for (int i = 0; i < STEPS_PER_STAGE; i++)
        begin
            t     = {r.rem, r.quo[COORD_W-1]};
            r.quo = {r.quo[COORD_W-2:0], 1'b0};
            if (t >= {1'b0, d})
            begin
                t        = t - {1'b0, d};
                r.quo[0] = 1'b1;
            end
            r.rem = t[DIM_W-1:0];
        end
        return r;
    endfunction

endpackage

// File: rtl/nnsa_if.sv
// Valid/ready channel interfaces for destination coordinates and address results.
`timescale 1ns / 1ps

interface nnsa_coord_if;
    import nnsa_pkg::*;

    logic   valid;
    logic   ready;
    coord_t target_x;
    coord_t target_y;

    modport source (output valid, output target_x, output target_y, input ready);
    modport sink   (input valid, input target_x, input target_y, output ready);
endinterface

interface nnsa_addr_if;
    import nnsa_pkg::*;

    logic   valid;
    logic   ready;
    coord_t source_x;
    coord_t source_y;
    addr_t  source_address;
    addr_t  target_address;

    modport source (output valid, output source_x, output source_y,
                    output source_address, output target_address, input ready);
    modport sink   (input valid, input source_x, input source_y,
                    input source_address, input target_address, output ready);
endinterface

// File: rtl/nnsa_divider.sv
// Pipelined restoring divider lane, STEPS_PER_STAGE quotient bits per stage.
`timescale 1ns / 1ps

module nnsa_divider (
    input  logic                              clk,
    input  logic [nnsa_pkg::DIV_STAGES-1:0]   adv,
    input  nnsa_pkg::dim_t                    divisor,
    input  nnsa_pkg::div_lane_t               lane_in,
    output nnsa_pkg::div_lane_t               lane_out
);
    import nnsa_pkg::*;

    div_lane_t stage_reg  [DIV_STAGES];
    div_lane_t stage_next [DIV_STAGES];

    always_comb
    begin
        stage_next[0] = div_steps(lane_in, divisor);
        for (int k = 1; k < DIV_STAGES; k++)
        begin
            stage_next[k] = div_steps(stage_reg[k-1], divisor);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < DIV_STAGES; k++)
        begin
            if (adv[k])
            begin
                stage_reg[k] <= stage_next[k];
            end
        end
    end

    assign lane_out = stage_reg[DIV_STAGES-1];

endmodule

// File: rtl/nearest_neighbor_scale_address.sv
// Nearest-neighbor scaler address generator: top level.
//
// Takes one destination coordinate per clock while a stage is free or the output
// is ready, and returns the nearest source column and row (clamped to the source
// frame) with the linear source and destination addresses. The pipeline is
// one multiply stage, four divider stages and one address stage; the divider
// retires three quotient bits per stage, which fixes the depth. Any empty stage
// lets a new transfer in even while the output is stalled. Configuration
// writes take effect at once and must be made only while the pipeline is
// empty; a value of zero reads as one and values above 4096 saturate.
`timescale 1ns / 1ps

module nearest_neighbor_scale_address (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [nnsa_pkg::IDX_W-1:0]    cfg_index,
    input  nnsa_pkg::dim_t                cfg_data,
    nnsa_coord_if.sink                    coord,
    nnsa_addr_if.source                   addr
);
    import nnsa_pkg::*;
    `include "nearest_neighbor_scale_address_assert.svh"

    localparam int LAST = NUM_STAGES - 1;

    // configuration
    dim_t src_w_reg, src_h_reg, src_p_reg, tgt_w_reg, tgt_h_reg, tgt_p_reg;
    dim_t cfg_eff;

    assign cfg_eff = eff_dim(cfg_data);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_w_reg <= DIM_W'(1);
            src_h_reg <= DIM_W'(1);
            src_p_reg <= DIM_W'(1);
            tgt_w_reg <= DIM_W'(1);
            tgt_h_reg <= DIM_W'(1);
            tgt_p_reg <= DIM_W'(1);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_SOURCE_WIDTH:     src_w_reg <= cfg_eff;
                REG_SOURCE_HEIGHT:    src_h_reg <= cfg_eff;
                REG_SOURCE_ROW_PITCH: src_p_reg <= cfg_eff;
                REG_TARGET_WIDTH:     tgt_w_reg <= cfg_eff;
                REG_TARGET_HEIGHT:    tgt_h_reg <= cfg_eff;
                REG_TARGET_ROW_PITCH: tgt_p_reg <= cfg_eff;
                default:              ;
            endcase
        end
    end

    // pipeline control
    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] adv;
    logic                  in_fire;
    logic                  out_fire;

    always_comb
    begin
        adv[LAST] = !valid_reg[LAST] || addr.ready;
        for (int k = LAST - 1; k >= 0; k--)
        begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
    end

    always_comb
    begin
        valid_next[0] = adv[0] ? coord.valid : valid_reg[0];
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            valid_next[k] = adv[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign coord.ready = adv[0];
    assign in_fire     = coord.valid && coord.ready;
    assign out_fire    = addr.valid && addr.ready;

    // stage 0: products and range flags
    logic [PROD_W-1:0] nx_prod, ny_prod, ta_prod;
    addr_t             nx_reg, ny_reg;
    side_t             side_a_reg;
    side_t             side_a_next;

    assign nx_prod = PROD_W'(coord.target_x) * PROD_W'(src_w_reg);
    assign ny_prod = PROD_W'(coord.target_y) * PROD_W'(src_h_reg);
    assign ta_prod = PROD_W'(coord.target_y) * PROD_W'(tgt_p_reg)
                   + PROD_W'(coord.target_x);

    always_comb
    begin
        side_a_next.x_over         = {1'b0, coord.target_x} >= tgt_w_reg;
        side_a_next.y_over         = {1'b0, coord.target_y} >= tgt_h_reg;
        side_a_next.target_address = ta_prod[ADDR_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            nx_reg     <= nx_prod[ADDR_W-1:0];
            ny_reg     <= ny_prod[ADDR_W-1:0];
            side_a_reg <= side_a_next;
        end
    end

    // stages 1..DIV_STAGES: dividers and sideband
    div_lane_t lane_x_in, lane_y_in, lane_x_out, lane_y_out;
    side_t     side_reg [DIV_STAGES];

    assign lane_x_in.rem = {1'b0, nx_reg[ADDR_W-1:COORD_W]};
    assign lane_x_in.quo = nx_reg[COORD_W-1:0];
    assign lane_y_in.rem = {1'b0, ny_reg[ADDR_W-1:COORD_W]};
    assign lane_y_in.quo = ny_reg[COORD_W-1:0];

    nnsa_divider u_div_x (
        .clk      (clk),
        .adv      (adv[DIV_STAGES:1]),
        .divisor  (tgt_w_reg),
        .lane_in  (lane_x_in),
        .lane_out (lane_x_out)
    );

    nnsa_divider u_div_y (
        .clk      (clk),
        .adv      (adv[DIV_STAGES:1]),
        .divisor  (tgt_h_reg),
        .lane_in  (lane_y_in),
        .lane_out (lane_y_out)
    );

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            side_reg[0] <= side_a_reg;
        end
        for (int k = 1; k < DIV_STAGES; k++)
        begin
            if (adv[k+1])
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // last stage: clamp and source address
    coord_t            sx_next, sy_next;
    logic [PROD_W-1:0] sa_prod;
    coord_t            sx_reg, sy_reg;
    addr_t             sa_reg, ta_reg;
    dim_t              sw_last, sh_last;

    assign sw_last = src_w_reg - DIM_W'(1);
    assign sh_last = src_h_reg - DIM_W'(1);
    assign sx_next = side_reg[DIV_STAGES-1].x_over ? sw_last[COORD_W-1:0] : lane_x_out.quo;
    assign sy_next = side_reg[DIV_STAGES-1].y_over ? sh_last[COORD_W-1:0] : lane_y_out.quo;
    assign sa_prod = PROD_W'(sy_next) * PROD_W'(src_p_reg) + PROD_W'(sx_next);

    always_ff @(posedge clk)
    begin
        if (adv[LAST])
        begin
            sx_reg <= sx_next;
            sy_reg <= sy_next;
            sa_reg <= sa_prod[ADDR_W-1:0];
            ta_reg <= side_reg[DIV_STAGES-1].target_address;
        end
    end

    assign addr.valid          = valid_reg[LAST];
    assign addr.source_x       = sx_reg;
    assign addr.source_y       = sy_reg;
    assign addr.source_address = sa_reg;
    assign addr.target_address = ta_reg;

    // checks
    `NNSA_ASSERT(a_ready_when_room, !(&valid_reg) |-> coord.ready, "input stalled with an empty stage")
    `NNSA_ASSERT_NEXT(a_fire_fills_first, in_fire, valid_reg[0], "accepted transfer not captured")
    `NNSA_ASSERT(a_count_kept, $countones(valid_reg) == $past($countones(valid_reg)) + $past(in_fire) - $past(out_fire), "item lost or duplicated in pipeline")

endmodule
